// ===== design/mavu_pkg.sv =====
package mavu_pkg;

   localparam int ANGLE_BITS = 12;
   localparam int TICK_HZ    = 1000000;

   // usable angle bits of the 12-bit sample field
   localparam int ANG_W      = (ANGLE_BITS < 12) ? ANGLE_BITS : 12;

   localparam int TICK_W     = $clog2(TICK_HZ + 1);
   localparam int NUM_W      = 32 + TICK_W;
   // divider retires two quotient bits per cycle
   localparam int DIV_STEPS  = (NUM_W + 1) / 2;
   localparam int NUM_PAD    = 2 * DIV_STEPS;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WRAP_THRESHOLD = 2'd0,
      CSR_FALLBACK_TICKS = 2'd1,
      CSR_TIMER_TOP      = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [11:0] wrap_threshold;
      logic [15:0] fallback_ticks;
      logic [15:0] timer_top;
   } cfg_type;

   // one classified sample waiting for the velocity divider
   typedef struct packed {
      logic [31:0] position;
      logic        fallback;
      logic        negative;
      logic [31:0] delta_mag;
      logic [15:0] interval;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [31:0] position_counts;
      logic [31:0] velocity_cps;
      logic        interval_fallback;
   } result_type;

endpackage

// ===== design/mavu_if.sv =====
interface mavu_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] raw_angle;
   logic [15:0] timer_now;

   modport source (output valid, raw_angle, timer_now, input ready);
   modport sink   (input valid, raw_angle, timer_now, output ready);
endinterface

interface mavu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] position_counts;
   logic [31:0] velocity_cps;
   logic        interval_fallback;

   modport source (output valid, position_counts, velocity_cps, interval_fallback,
                   input ready);
   modport sink   (input valid, position_counts, velocity_cps, interval_fallback,
                   output ready);
endinterface

interface mavu_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/mavu_front.sv =====
module mavu_front
   import mavu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   input  logic [11:0] in_raw_angle,
   input  logic [15:0] in_timer_now,
   input  logic        accept,
   output job_type     job
);

   logic [11:0] last_angle_ff, last_angle_in;
   logic [19:0] turn_ff, turn_in;
   logic [31:0] last_pos_ff, last_pos_in;
   logic [15:0] last_ts_ff, last_ts_in;

   logic [11:0]        angle;
   logic signed [12:0] d_angle;
   logic [12:0]        d_mag;
   logic [31:0]        pos;
   logic [31:0]        dpos;
   logic signed [17:0] span;
   logic [15:0]        interval;
   logic               fb;

   always_comb begin
      angle   = 12'(in_raw_angle[ANG_W-1:0]);
      d_angle = $signed({1'b0, angle}) - $signed({1'b0, last_angle_ff});
      d_mag   = d_angle[12] ? 13'(-d_angle) : 13'(d_angle);

      turn_in = turn_ff;
      if (d_mag > {1'b0, cfg.wrap_threshold}) begin
         // positive jump means we wrapped backward through zero
         if (!d_angle[12]) begin
            turn_in = turn_ff - 20'd1;
         end else begin
            turn_in = turn_ff + 20'd1;
         end
      end

      pos  = (32'($signed(turn_in)) << ANGLE_BITS) + 32'(angle);
      dpos = pos - last_pos_ff;

      // down-counting timer
      span     = $signed({2'b00, cfg.timer_top}) - $signed({2'b00, in_timer_now})
                 + $signed({2'b00, last_ts_ff});
      fb       = 1'b0;
      interval = last_ts_ff - in_timer_now;
      if (in_timer_now >= last_ts_ff) begin
         interval = span[15:0];
         if (span[17] || span == 18'sd0) begin
            fb       = 1'b1;
            interval = (cfg.fallback_ticks == 16'd0) ? 16'd1 : cfg.fallback_ticks;
         end
      end

      job.position  = pos;
      job.fallback  = fb;
      job.negative  = dpos[31];
      job.delta_mag = dpos[31] ? (32'd0 - dpos) : dpos;
      job.interval  = interval;

      last_angle_in = angle;
      last_pos_in   = pos;
      last_ts_in    = in_timer_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_angle_ff <= '0;
         turn_ff       <= '0;
         last_pos_ff   <= '0;
         last_ts_ff    <= '0;
      end else if (accept && in_valid) begin
         last_angle_ff <= last_angle_in;
         turn_ff       <= turn_in;
         last_pos_ff   <= last_pos_in;
         last_ts_ff    <= last_ts_in;
      end
   end

endmodule

// ===== design/mavu_queue.sv =====
module mavu_queue
   import mavu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_data,
   input  logic             pop,
   output job_type          pop_data,
   output queue_status_type status
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == 2'd2);
      status.empty = (count_ff == 2'd0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + 2'(do_push) - 2'(do_pop);
      pop_data     = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/mavu_back.sv =====
module mavu_back
   import mavu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          q_data,
   output logic             q_pop,
   output logic             out_valid,
   input  logic             out_ready,
   output result_type       out_data
);

   localparam logic [NUM_PAD-1:0] TICK_K = NUM_PAD'(TICK_HZ);

   back_state_type state_ff, state_in;

   job_type            job_ff;
   logic [NUM_PAD-1:0] num_ff, num_in;
   logic [NUM_PAD-1:0] quo_ff, quo_in;
   logic [15:0]        rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_data_ff, out_data_in;

   logic        load_out;
   logic [16:0] r_a, r_b;
   logic [15:0] rem_a;
   logic        q_a, q_b;
   logic [31:0] vel;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!q_status.empty) state_in = BK_MUL;
         BK_MUL:  state_in = BK_DIV;
         BK_DIV:  if (step_ff == '0) state_in = BK_DONE;
         BK_DONE: if (!out_valid_ff || out_ready) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // two restoring steps per cycle
   always_comb begin
      r_a   = {rem_ff, num_ff[NUM_PAD-1]};
      q_a   = (r_a >= {1'b0, job_ff.interval});
      rem_a = q_a ? 16'(r_a - {1'b0, job_ff.interval}) : r_a[15:0];
      r_b   = {rem_a, num_ff[NUM_PAD-2]};
      q_b   = (r_b >= {1'b0, job_ff.interval});
   end

   always_comb begin
      if (!job_ff.negative) begin
         vel = (|quo_ff[NUM_PAD-1:31]) ? 32'h7FFF_FFFF : quo_ff[31:0];
      end else if ((|quo_ff[NUM_PAD-1:32]) || (quo_ff[31] && (|quo_ff[30:0]))) begin
         vel = 32'h8000_0000;
      end else begin
         vel = 32'd0 - quo_ff[31:0];
      end
   end

   always_comb begin
      q_pop    = (state_ff == BK_IDLE) && !q_status.empty;
      load_out = (state_ff == BK_DONE) && (!out_valid_ff || out_ready);

      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (state_ff == BK_MUL) begin
         num_in  = NUM_PAD'(job_ff.delta_mag) * TICK_K;
         quo_in  = '0;
         rem_in  = '0;
         step_in = STEP_W'(DIV_STEPS - 1);
      end else if (state_ff == BK_DIV) begin
         num_in  = num_ff << 2;
         quo_in  = {quo_ff[NUM_PAD-3:0], q_a, q_b};
         rem_in  = q_b ? 16'(r_b - {1'b0, job_ff.interval}) : r_b[15:0];
         step_in = step_ff - STEP_W'(1);
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (load_out) begin
         out_valid_in                  = 1'b1;
         out_data_in.position_counts   = job_ff.position;
         out_data_in.velocity_cps      = vel;
         out_data_in.interval_fallback = job_ff.fallback;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_data;
      end
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      out_data_ff <= out_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== design/multiturn_angle_velocity_unit.sv =====
// Each sample passes in order through pickup from the queue, the TICK_HZ multiply, the shared divider
// (2 quotient bits a cycle over a 52-bit numerator) and writeback to rsp_ch; the back end finishes
// one sample before it picks up the next.
// Input is taken every cycle until the two-entry queue fills.
// Synchronous active-high reset restores register defaults and zeros the angle/turn/time state.
module multiturn_angle_velocity_unit
   import mavu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mavu_req_if.sink   req_ch,
   mavu_rsp_if.source rsp_ch,
   mavu_csr_if.sink   csr_ch
);

   cfg_type          cfg_ff, cfg_in;
   job_type          front_job, q_data;
   queue_status_type q_status;
   logic             q_pop;
   logic             req_xfer;
   logic             out_valid;
   result_type       out_data;
   csr_index_type    csr_idx;

   assign req_ch.ready = !q_status.full;
   assign req_xfer     = req_ch.valid && !q_status.full;
   assign csr_ch.ready = 1'b1;
   assign csr_idx      = csr_index_type'(csr_ch.index);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_idx)
            CSR_WRAP_THRESHOLD: cfg_in.wrap_threshold = csr_ch.data[11:0];
            CSR_FALLBACK_TICKS: cfg_in.fallback_ticks = csr_ch.data;
            CSR_TIMER_TOP:      cfg_in.timer_top      = csr_ch.data;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wrap_threshold <= 12'd3276;
         cfg_ff.fallback_ticks <= 16'd1000;
         cfg_ff.timer_top      <= 16'd65535;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mavu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_ch.valid),
      .in_raw_angle (req_ch.raw_angle),
      .in_timer_now (req_ch.timer_now),
      .accept       (req_xfer),
      .job          (front_job)
   );

   mavu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_data (front_job),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   mavu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .out_valid (out_valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.valid             = out_valid;
   assign rsp_ch.position_counts   = out_data.position_counts;
   assign rsp_ch.velocity_cps      = out_data.velocity_cps;
   assign rsp_ch.interval_fallback = out_data.interval_fallback;

endmodule

// ===== design/mavu_checker.sv =====
module mavu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_position_counts,
   input logic [31:0] rsp_velocity_cps,
   input logic        rsp_interval_fallback
);

   // samples taken but not yet delivered
   logic [2:0] pending_ff, pending_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer   = req_valid && req_ready;
   assign rsp_xfer   = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + 3'(req_xfer) - 3'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_no_phantom_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result shown with no sample outstanding");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 3'd4 |-> !req_ready)
      else $error("input taken beyond internal capacity");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_position_counts)
         && $stable(rsp_velocity_cps) && $stable(rsp_interval_fallback))
      else $error("stalled result payload changed");

endmodule

bind multiturn_angle_velocity_unit mavu_checker u_mavu_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_ch.valid),
   .req_ready             (req_ch.ready),
   .rsp_valid             (rsp_ch.valid),
   .rsp_ready             (rsp_ch.ready),
   .rsp_position_counts   (rsp_ch.position_counts),
   .rsp_velocity_cps      (rsp_ch.velocity_cps),
   .rsp_interval_fallback (rsp_ch.interval_fallback)
);
